// ===== rtl/afu_pkg.sv =====
// package: request codes, pipeline depth and interpolation tables for the activation unit
package afu_pkg;

  typedef enum logic [2:0] {
    REQ_SIGMOID   = 3'd0,
    REQ_SIGMOID_D = 3'd1,
    REQ_TANH      = 3'd2,
    REQ_TANH_D    = 3'd3,
    REQ_ELU       = 3'd4,
    REQ_ELU_D     = 3'd5
  } req_t;

  // q.16 one, last table index and request-to-result latency in cycles
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [4:0]  TAB_LAST  = 5'd16;
  localparam int          LATENCY   = 6;

  typedef logic [16:0] tab_val_t;

  // sigmoid sampled every 0.5 on [0, 8]
  function automatic tab_val_t sig_entry(input logic [4:0] idx);
    tab_val_t v;
    unique case (idx)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd40793;
      5'd2:    v = 17'd47911;
      5'd3:    v = 17'd53581;
      5'd4:    v = 17'd57724;
      5'd5:    v = 17'd60565;
      5'd6:    v = 17'd62428;
      5'd7:    v = 17'd63615;
      5'd8:    v = 17'd64357;
      5'd9:    v = 17'd64816;
      5'd10:   v = 17'd65097;
      5'd11:   v = 17'd65269;
      5'd12:   v = 17'd65374;
      5'd13:   v = 17'd65438;
      5'd14:   v = 17'd65476;
      5'd15:   v = 17'd65500;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

  // exp(-x) sampled every 0.5 on [0, 8]
  function automatic tab_val_t exp_entry(input logic [4:0] idx);
    tab_val_t v;
    unique case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd39749;
      5'd2:    v = 17'd24109;
      5'd3:    v = 17'd14623;
      5'd4:    v = 17'd8869;
      5'd5:    v = 17'd5380;
      5'd6:    v = 17'd3263;
      5'd7:    v = 17'd1979;
      5'd8:    v = 17'd1200;
      5'd9:    v = 17'd728;
      5'd10:   v = 17'd442;
      5'd11:   v = 17'd268;
      5'd12:   v = 17'd162;
      5'd13:   v = 17'd99;
      5'd14:   v = 17'd60;
      5'd15:   v = 17'd36;
      default: v = 17'd22;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/activation_function_unit.sv =====
// activation function unit: sigmoid, tanh, elu and their derivatives
//
// usage: drive req_type and x_value with start high; the request is taken
// at any clock edge where start is high and busy is low. busy is high only
// while rst is high, so a request can enter every cycle.
// the result is driven on y_value with result_valid high for exactly one
// cycle, once the request has passed the stage registers and the output
// register; results come in request order. one result per request,
// one request per cycle sustained.
// pipeline: input register, table read, interpolation multiply,
// interpolate and mirror, 17x17 product, fixed-point conversion and
// saturation. the receiver cannot stall, so there is no backpressure path.
// elu_alpha is written through cfg_valid/cfg_ready (ready always high once
// out of reset); the user must write it only while no request is in flight:
// the block itself does not enforce this.
// synchronous reset clears all stage valid bits and sets elu_alpha to 13107.
module activation_function_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   req_type,
  input  logic signed [DATA_WIDTH-1:0] x_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [15:0]                  elu_alpha,
  output logic                         result_valid,
  output logic signed [DATA_WIDTH-1:0] y_value
);

  localparam int TW    = DATA_WIDTH + 18;
  localparam int SH_L  = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
  localparam int SH_R  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int CW    = 48;
  localparam int SHO_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHO_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [CW-1:0] Y_HI = (CW'(1) <<< (DATA_WIDTH - 1)) - CW'(1);
  localparam logic signed [CW-1:0] Y_LO = -Y_HI - CW'(1);

  logic [15:0] alpha;

  // stage 1: request register
  logic                         v1;
  logic [2:0]                   sel1;
  logic signed [DATA_WIDTH-1:0] x1;
  // stage 2: table entries
  logic                         v2;
  logic [2:0]                   sel2;
  logic                         neg2;
  logic signed [DATA_WIDTH-1:0] x2;
  logic [16:0]                  a2, b2;
  logic [14:0]                  f2;
  // stage 3: interpolation product
  logic                         v3;
  logic [2:0]                   sel3;
  logic                         neg3;
  logic signed [DATA_WIDTH-1:0] x3;
  logic [16:0]                  a3;
  logic                         down3;
  logic [31:0]                  prod3;
  // stage 4: function value in q.16
  logic                         v4;
  logic [2:0]                   sel4;
  logic                         neg4;
  logic signed [DATA_WIDTH-1:0] x4;
  logic [16:0]                  val4;
  // stage 5: second product
  logic                         v5;
  logic [2:0]                   sel5;
  logic                         neg5;
  logic signed [DATA_WIDTH-1:0] x5;
  logic [16:0]                  val5;
  logic [33:0]                  mprod5;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // stage 1 logic: magnitude to q.16, segment, fraction and table entries
  logic                  neg_c;
  logic [DATA_WIDTH-1:0] mag_c;
  logic [TW-1:0]         t_c, tt_c;
  logic                  sat_c, use_exp_c;
  logic [4:0]            seg_c;
  logic [16:0]           a_c, b_c;

  always_comb begin
    neg_c     = x1[DATA_WIDTH-1];
    mag_c     = neg_c ? (~x1 + DATA_WIDTH'(1)) : x1;
    t_c       = ({{18{1'b0}}, mag_c} << SH_L) >> SH_R;
    tt_c      = (sel1 == afu_pkg::REQ_TANH || sel1 == afu_pkg::REQ_TANH_D) ? (t_c << 1) : t_c;
    sat_c     = |tt_c[TW-1:19];
    seg_c     = {1'b0, tt_c[18:15]};
    use_exp_c = (sel1 == afu_pkg::REQ_ELU || sel1 == afu_pkg::REQ_ELU_D);
    if (sat_c) begin
      a_c = use_exp_c ? afu_pkg::exp_entry(afu_pkg::TAB_LAST)
                      : afu_pkg::sig_entry(afu_pkg::TAB_LAST);
      b_c = a_c;
    end else begin
      a_c = use_exp_c ? afu_pkg::exp_entry(seg_c) : afu_pkg::sig_entry(seg_c);
      b_c = use_exp_c ? afu_pkg::exp_entry(seg_c + 5'd1) : afu_pkg::sig_entry(seg_c + 5'd1);
    end
  end

  // stage 2 logic: slope times fraction
  logic        down_c;
  logic [16:0] diff_c;
  always_comb begin
    down_c = b2 < a2;
    diff_c = down_c ? (a2 - b2) : (b2 - a2);
  end

  // stage 3 logic: interpolate and mirror sigmoid for negative arguments
  logic [16:0] d_c, iv_c, val_c;
  always_comb begin
    d_c  = prod3[31:15];
    iv_c = down3 ? (a3 - d_c) : (a3 + d_c);
    if (neg3 && sel3 != afu_pkg::REQ_ELU && sel3 != afu_pkg::REQ_ELU_D) begin
      val_c = afu_pkg::ONE_Q16 - iv_c;
    end else begin
      val_c = iv_c;
    end
  end

  // stage 4 logic: operands of the second product
  logic signed [18:0] tq_c;
  logic [16:0]        tm_c, opa_c, opb_c;
  always_comb begin
    tq_c = $signed({2'b00, val4} << 1) - $signed({2'b00, afu_pkg::ONE_Q16});
    tm_c = tq_c[18] ? 17'(-tq_c) : tq_c[16:0];
    unique case (sel4)
      afu_pkg::REQ_SIGMOID_D: begin
        opa_c = val4;
        opb_c = afu_pkg::ONE_Q16 - val4;
      end
      afu_pkg::REQ_TANH_D: begin
        opa_c = tm_c;
        opb_c = tm_c;
      end
      afu_pkg::REQ_ELU: begin
        opa_c = {1'b0, alpha};
        opb_c = afu_pkg::ONE_Q16 - val4;
      end
      afu_pkg::REQ_ELU_D: begin
        opa_c = {1'b0, alpha};
        opb_c = val4;
      end
      default: begin
        opa_c = '0;
        opb_c = '0;
      end
    endcase
  end

  // stage 5 logic: signed q.16 result, conversion and saturation
  logic [17:0]          mp_c;
  logic signed [19:0]   r_c;
  logic [19:0]          rmag_c;
  logic [CW-1:0]        cm_c;
  logic signed [CW-1:0] cv_c;
  logic [DATA_WIDTH-1:0] y_c;
  always_comb begin
    mp_c = mprod5[33:16];
    unique case (sel5)
      afu_pkg::REQ_SIGMOID:   r_c = $signed({3'b000, val5});
      afu_pkg::REQ_SIGMOID_D: r_c = $signed({2'b00, mp_c});
      afu_pkg::REQ_TANH:      r_c = $signed({2'b00, val5, 1'b0})
                                    - $signed({3'b000, afu_pkg::ONE_Q16});
      afu_pkg::REQ_TANH_D:    r_c = $signed({3'b000, afu_pkg::ONE_Q16}) - $signed({2'b00, mp_c});
      afu_pkg::REQ_ELU:       r_c = -$signed({2'b00, mp_c});
      afu_pkg::REQ_ELU_D:     r_c = neg5 ? $signed({2'b00, mp_c})
                                         : $signed({3'b000, afu_pkg::ONE_Q16});
      default:                r_c = '0;
    endcase
    rmag_c = r_c[19] ? 20'(-r_c) : 20'(r_c);
    cm_c   = ({{(CW-20){1'b0}}, rmag_c} << SHO_L) >> SHO_R;
    cv_c   = r_c[19] ? -$signed(cm_c) : $signed(cm_c);
    if (cv_c > Y_HI) begin
      y_c = Y_HI[DATA_WIDTH-1:0];
    end else if (cv_c < Y_LO) begin
      y_c = Y_LO[DATA_WIDTH-1:0];
    end else begin
      y_c = cv_c[DATA_WIDTH-1:0];
    end
    // elu passes nonnegative arguments through untouched
    if (sel5 == afu_pkg::REQ_ELU && !neg5) begin
      y_c = x5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= 16'd13107;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alpha <= elu_alpha;
      end
      v1           <= start && !busy;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= v4;
      result_valid <= v5;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    sel1   <= req_type;
    x1     <= x_value;
    sel2   <= sel1;
    neg2   <= neg_c;
    x2     <= x1;
    a2     <= a_c;
    b2     <= b_c;
    f2     <= tt_c[14:0];
    sel3   <= sel2;
    neg3   <= neg2;
    x3     <= x2;
    a3     <= a2;
    down3  <= down_c;
    prod3  <= 32'(diff_c) * 32'(f2);
    sel4   <= sel3;
    neg4   <= neg3;
    x4     <= x3;
    val4   <= val_c;
    sel5   <= sel4;
    neg5   <= neg4;
    x5     <= x4;
    val5   <= val4;
    mprod5 <= 34'(opa_c) * 34'(opb_c);
    y_value <= y_c;
  end

endmodule

// ===== rtl/afu_checker.sv =====
// port-level checker for the activation function unit, bound to the top level
module afu_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [2:0]                   req_type,
  input logic signed [DATA_WIDTH-1:0] x_value,
  input logic                         result_valid,
  input logic signed [DATA_WIDTH-1:0] y_value
);

  logic req_c;
  assign req_c = start && !busy;

  // every request gets its result after afu_pkg::LATENCY
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_c |-> ##(afu_pkg::LATENCY) result_valid)
    else $error("missing result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(req_c, afu_pkg::LATENCY))
    else $error("result without request");

  // sigmoid is never negative
  a_sigmoid_sign: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(req_c && req_type == afu_pkg::REQ_SIGMOID, afu_pkg::LATENCY))
      |-> !y_value[DATA_WIDTH-1])
    else $error("negative sigmoid");

  // elu of a nonnegative argument is the argument
  a_elu_pass: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(req_c && req_type == afu_pkg::REQ_ELU && !x_value[DATA_WIDTH-1],
                           afu_pkg::LATENCY))
      |-> y_value == $past(x_value, afu_pkg::LATENCY))
    else $error("elu passthrough wrong");

endmodule

bind activation_function_unit afu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_afu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .x_value      (x_value),
  .result_valid (result_valid),
  .y_value      (y_value)
);
